// File: src/ieu_pkg.sv
package ieu_pkg;

	localparam int RegCount = 16;
	localparam int RegAw = $clog2(RegCount);

	typedef enum logic [3:0] {
		OP_MOV_REG = 4'd0,
		OP_MOV_MEM = 4'd1,
		OP_MOV_IMM = 4'd2,
		OP_SUB_REG = 4'd3,
		OP_SUB_IMM = 4'd4,
		OP_STORE   = 4'd5,
		OP_JMP     = 4'd6,
		OP_JNZ     = 4'd7,
		OP_JZ      = 4'd8,
		OP_HALT    = 4'd9,
		OP_INTPT   = 4'd10,
		OP_RD_RET  = 4'd11,
		OP_INVALID = 4'd12
	} op_t;

	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_HALT    = 2'd1;
	localparam logic [1:0] ST_DUMP    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic [7:0] INT_DUMP  = 8'h80;
	localparam logic [7:0] INT_COUNT = 8'h81;

	typedef struct packed {
		logic [3:0]  op;
		logic [63:0] code_bytes;
		logic [7:0]  code_byte_nine;
		logic [63:0] read_data;
		logic        read_fault;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  mem_request;
		logic [63:0] mem_address;
		logic [1:0]  mem_size;
		logic [63:0] write_data;
		logic [63:0] ip_value;
		logic [3:0]  flags_value;
		logic [1:0]  status;
	} out_item_t;

	function automatic logic [63:0] size_mask(input logic [1:0] s);
		unique case (s)
			2'd0: size_mask = 64'hff;
			2'd1: size_mask = 64'hffff;
			2'd2: size_mask = 64'hffff_ffff;
			default: size_mask = '1;
		endcase
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] v);
		sext32 = {{32{v[31]}}, v};
	endfunction

endpackage

// File: src/ieu_queue.sv
module ieu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ieu_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ieu_pkg::in_item_t out_data
);
	import ieu_pkg::*;

	// two-entry skid queue between front and back
	in_item_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wr_q == rd_q))
		else $error("empty queue pointers differ");
endmodule

// File: src/ieu_exec.sv
module ieu_exec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        stack_pointer,
	input  logic               in_valid,
	output logic               in_ready,
	input  ieu_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ieu_pkg::out_item_t out_data
);
	import ieu_pkg::*;

	logic [63:0]      rf_q [RegCount];
	logic [63:0]      ip_q;
	logic [3:0]       fl_q;
	logic             lp_q;
	logic [RegAw-1:0] ld_q;
	logic [1:0]       lw_q;
	logic [1:0]       st_q;
	out_item_t        res_q;
	logic             res_v_q;

	logic fire;
	assign in_ready  = !res_v_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = res_v_q;
	assign out_data  = res_q;

	logic [7:0] b [10];
	always_comb begin
		b[0] = 8'h00;
		for (int k = 1; k <= 8; k++) b[k] = in_data.code_bytes[8*(k-1) +: 8];
		b[9] = in_data.code_byte_nine;
	end

	logic [7:0]  tb, first, second;
	logic [RegAw-1:0] dest;
	logic [1:0]  sh;
	logic        ign, dsel;
	logic [63:0] d4a, d2a, d4b, d2b, disp_a, disp_b, r_first, r_shi, r_slo;
	assign tb     = b[1];
	assign first  = b[2];
	assign second = b[3];
	assign dest   = tb[7:4];
	assign sh     = first[3:2];
	assign ign    = first[0];
	assign dsel   = first[1];
	assign d4a = {32'd0, b[6], b[5], b[4], b[3]};
	assign d2a = {48'd0, b[4], b[3]};
	assign d4b = {32'd0, b[7], b[6], b[5], b[4]};
	assign d2b = {48'd0, b[5], b[4]};
	assign disp_a = dsel ? d2a : d4a;
	assign disp_b = dsel ? d2b : d4b;
	assign r_first = rf_q[first[7:4]];
	assign r_shi   = rf_q[second[7:4]];
	assign r_slo   = rf_q[second[3:0]];

	// effective address; ip advance counted from after the 2-byte header
	logic [63:0] ea;
	logic [3:0]  ea_len;
	logic [63:0] ip2;
	assign ip2 = ip_q + 64'd2;
	always_comb begin
		unique case (tb[3:2])
			2'd0: begin
				ea_len = 4'd4;
				ea = ip2 + 64'd4 + sext32({b[5], b[4], b[3], b[2]});
			end
			2'd1: begin
				ea_len = dsel ? 4'd3 : 4'd5;
				ea = ign ? ((stack_pointer << sh) + disp_a)
				         : (stack_pointer + (r_first << sh) + disp_a);
			end
			2'd2: begin
				ea_len = (dsel ? 4'd2 : 4'd4) + (ign ? 4'd2 : 4'd1);
				ea = ign ? (r_shi + (r_slo << sh) + disp_b)
				         : ((r_first << sh) + disp_a);
			end
			default: begin
				ea_len = 4'd8;
				ea = {b[9], b[8], b[7], b[6], b[5], b[4], b[3], b[2]};
			end
		endcase
	end

	logic [63:0] imm;
	always_comb begin
		unique case (tb[3:2])
			2'd0: imm = {56'd0, b[2]};
			2'd1: imm = {48'd0, b[3], b[2]};
			2'd2: imm = {32'd0, b[5], b[4], b[3], b[2]};
			default: imm = {b[9], b[8], b[7], b[6], b[5], b[4], b[3], b[2]};
		endcase
	end

	logic [63:0] sl, sr, sd;
	logic [3:0]  sf;
	assign sl = rf_q[dest];
	assign sr = (in_data.op == OP_SUB_IMM) ? imm : rf_q[tb[3:0]];
	assign sd = sl - sr;
	assign sf = {sd[63], ((sl ^ sr) & (sl ^ sd)) >> 63 != 64'd0, sl < sr, sd == 64'd0};

	logic [63:0] r0m;
	assign r0m = rf_q[0] - 64'd1;

	// next-state and result
	logic [63:0]      n_ip, wv;
	logic [3:0]       n_fl;
	logic [1:0]       n_st;
	logic             we, n_lp, set_ld;
	logic [RegAw-1:0] wa;
	out_item_t        r;
	always_comb begin
		n_ip = ip_q; n_fl = fl_q; n_st = st_q; n_lp = lp_q; set_ld = 1'b0;
		we = 1'b0; wa = dest; wv = '0;
		r = '0;
		if (in_data.op == OP_RD_RET) begin
			if (lp_q) begin
				we = 1'b1; wa = ld_q; n_lp = 1'b0;
				wv = in_data.read_fault ? 64'd0 : (in_data.read_data & size_mask(lw_q));
			end
		end else if (st_q == ST_RUN) begin
			case (in_data.op)
				OP_MOV_REG: begin
					n_ip = ip2; we = 1'b1; wv = rf_q[tb[3:0]];
				end
				OP_MOV_MEM, OP_STORE: begin
					n_ip = ip2 + {60'd0, ea_len};
					r.mem_address = ea;
					r.mem_size = tb[1:0];
					if (in_data.op == OP_MOV_MEM) begin
						r.mem_request = REQ_READ; n_lp = 1'b1; set_ld = 1'b1;
					end else begin
						r.mem_request = REQ_WRITE;
						r.write_data = rf_q[dest] & size_mask(tb[1:0]);
					end
				end
				OP_MOV_IMM: begin
					n_ip = ip2 + (64'd1 << tb[3:2]); we = 1'b1; wv = imm;
				end
				OP_SUB_IMM: begin
					n_ip = ip2 + (64'd1 << tb[3:2]); we = 1'b1; wv = sd; n_fl = sf;
				end
				OP_SUB_REG: begin
					n_ip = ip2; we = 1'b1; wv = sd; n_fl = sf;
				end
				OP_JMP, OP_JNZ, OP_JZ: begin
					n_ip = ip_q + 64'd5;
					if (in_data.op == OP_JMP || (in_data.op == OP_JNZ && !fl_q[0])
					    || (in_data.op == OP_JZ && fl_q[0]))
						n_ip = ip_q + 64'd5 + sext32({b[4], b[3], b[2], b[1]});
				end
				OP_HALT: begin
					n_ip = ip_q + 64'd1; n_st = ST_HALT;
				end
				OP_INTPT: begin
					n_ip = ip2;
					if (tb == INT_DUMP) n_st = ST_DUMP;
					else if (tb == INT_COUNT) begin
						we = 1'b1; wa = '0; wv = r0m;
						n_fl = {fl_q[3:1], r0m == 64'd0};
					end
				end
				default: n_st = ST_INVALID;
			endcase
		end
		r.ip_value = n_ip; r.flags_value = n_fl; r.status = n_st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) rf_q[i] <= '0;
			ip_q <= '0; fl_q <= '0; lp_q <= 1'b0; ld_q <= '0; lw_q <= '0;
			st_q <= ST_RUN; res_v_q <= 1'b0;
		end else begin
			if (fire) begin
				if (we) rf_q[wa] <= wv;
				ip_q <= n_ip; fl_q <= n_fl; st_q <= n_st; lp_q <= n_lp;
				if (set_ld) begin
					ld_q <= dest; lw_q <= tb[1:0];
				end
			end
			if (fire) res_v_q <= 1'b1;
			else if (out_ready) res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_q <= r;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !out_ready) |=> $stable(res_q))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && st_q != ST_RUN && in_data.op != OP_RD_RET) |=> $stable(ip_q))
		else $error("stopped machine moved ip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && in_data.op == OP_RD_RET) |=> !lp_q)
		else $error("load still pending after return");
endmodule

// File: src/instruction_execute_unit.sv
// Instruction execute unit for a small 64-bit register machine.
// Channels: in (in_valid/in_ready/in_data) takes one decoded instruction
// or read return per beat; out (out_valid/out_ready/out_data) gives
// exactly one result beat per input beat, in order.
// cfg (cfg_valid/cfg_ready/cfg_data) writes the stack pointer; it is
// always ready and is meant to be written only while the unit is idle.
// Front: a two-entry queue takes input beats. Back: the execute stage
// reads the register file, computes address, flags and ip, updates state
// and registers the result.
// Path: an accepted input beat is first stored in the queue; the execute
// stage then takes it from the queue and registers its result.
// Throughput: one item per cycle while the receiver keeps out_ready high.
// Reset clears registers, ip, flags, pending load, status and stack pointer.
// When the receiver stalls the result register holds; the queue absorbs
// two more beats before in_ready drops.
module instruction_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ieu_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ieu_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [63:0]        cfg_data
);
	import ieu_pkg::*;

	logic [63:0] sp_q;
	in_item_t    q_data;
	logic        q_valid, q_ready;

	assign cfg_ready = 1'b1;

	// stack pointer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sp_q <= '0;
		else if (cfg_valid) sp_q <= cfg_data;
	end

	ieu_queue u_queue (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_data,
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	ieu_exec u_exec (
		.clk, .arst_n,
		.stack_pointer(sp_q),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid, .out_ready, .out_data
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> sp_q == $past(cfg_data))
		else $error("stack pointer write lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> in_valid)
		else $error("input beat withdrawn");
endmodule
